// ===== rtl/slfr_pkg.sv =====
`default_nettype none
package slfr_pkg;

  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_ENQ = 8'h05;
  // Link-level answer bytes; the block never decodes them.
  localparam logic [7:0] BYTE_ACK  = 8'h06;
  localparam logic [7:0] BYTE_NACK = 8'h15;
  localparam logic [7:0] MIN_BODY  = 8'd6;

  typedef enum logic [2:0] {
    EV_POLL    = 3'd0,
    EV_DROP    = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_ACK     = 3'd3,
    EV_NACK    = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef struct packed {
    logic       valid;
    event_t     ev;
    logic [7:0] data;
    logic [7:0] count;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/slfr_in_reg.sv =====
`default_nettype none
module slfr_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       advance,
  output logic            byte_valid,
  output logic [7:0]      byte_value
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // A new beat may enter when the register is empty or is being consumed now.
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  assign byte_valid = valid_r;
  assign byte_value = byte_r;

endmodule
`default_nettype wire

// ===== rtl/slfr_frame_fsm.sv =====
`default_nettype none
module slfr_frame_fsm (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] rx_byte,
  output slfr_pkg::result_t res
);

  import slfr_pkg::*;

  phase_t     phase_r,    phase_nxt;
  logic [7:0] len_r,      len_nxt;
  logic [7:0] pos_r,      pos_nxt;
  logic [7:0] xor_r,      xor_nxt;
  logic [7:0] cmd_r,      cmd_nxt;
  logic       etx_ok_r,   etx_ok_nxt;

  logic [8:0] pos_p1;
  logic [8:0] pos_p2;
  logic [8:0] pos_p3;
  logic [8:0] len_w;
  logic       frame_good;

  assign pos_p1 = {1'b0, pos_r} + 9'd1;
  assign pos_p2 = {1'b0, pos_r} + 9'd2;
  assign pos_p3 = {1'b0, pos_r} + 9'd3;
  assign len_w  = {1'b0, len_r};
  assign frame_good = (len_r >= MIN_BODY) && etx_ok_r && (rx_byte == xor_r);

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    xor_nxt    = xor_r;
    cmd_nxt    = cmd_r;
    etx_ok_nxt = etx_ok_r;
    res        = '{valid: 1'b0, ev: EV_POLL, data: 8'd0, count: 8'd0};
    unique case (phase_r)
      PH_LEN: begin
        len_nxt    = rx_byte;
        xor_nxt    = rx_byte;
        pos_nxt    = 8'd0;
        etx_ok_nxt = 1'b0;
        if (rx_byte == 8'd0) begin
          phase_nxt = PH_IDLE;
          res.valid = 1'b1;
          res.ev    = EV_NACK;
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        if (pos_p1 >= len_w) begin
          // Last body byte: it is the check byte.
          phase_nxt = PH_IDLE;
          pos_nxt   = 8'd0;
          res.valid = 1'b1;
          if (frame_good) begin
            res.ev    = EV_ACK;
            res.data  = cmd_r;
            res.count = len_r - MIN_BODY;
          end else begin
            res.ev = EV_NACK;
          end
        end else begin
          xor_nxt = xor_r ^ rx_byte;
          pos_nxt = pos_p1[7:0];
          if (pos_r == 8'd0) begin
            cmd_nxt = rx_byte;
          end
          if (pos_p2 == len_w) begin
            etx_ok_nxt = (rx_byte == BYTE_ETX);
          end
          // Payload sits after the command and three host status bytes,
          // and before the ETX and check bytes.
          if (pos_r >= 8'd4 && pos_p3 <= len_w) begin
            res.valid = 1'b1;
            res.ev    = EV_PAYLOAD;
            res.data  = rx_byte;
            res.count = pos_r - 8'd4;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        res.valid = 1'b1;
        if (rx_byte == BYTE_ENQ) begin
          res.ev = EV_POLL;
        end else if (rx_byte == BYTE_STX) begin
          phase_nxt = PH_LEN;
          res.valid = 1'b0;
        end else begin
          res.ev   = EV_DROP;
          res.data = rx_byte;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      len_r    <= 8'd0;
      pos_r    <= 8'd0;
      xor_r    <= 8'd0;
      cmd_r    <= 8'd0;
      etx_ok_r <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      xor_r    <= xor_nxt;
      cmd_r    <= cmd_nxt;
      etx_ok_r <= etx_ok_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/stx_length_frame_receiver_core.sv =====
// STX/length framed packet receiver with an XOR block check.
//
// Input channel (in_*): one received serial byte per beat on in_tdata.
// Result channel (out_*): at most one event per input byte. out_tuser holds
// the event code (poll, dropped byte, payload byte, frame ack, frame nack),
// out_tdata holds the data byte and the payload index or count.
// Payload bytes are forwarded as they arrive; a later nack tells the consumer
// to discard them.
//
// An accepted byte lands in an input register and is decoded straight into
// the output register once that register is empty or being read, so its
// event passes through both registers. The block takes one byte per cycle
// sustained unless the output stalls; eventless bytes still take a decode step.
// When the consumer holds out_tready low, the pending event stays put, one
// more byte waits in the input register, and then in_tready drops.
// Synchronous reset returns the receiver to idle, outside any frame, and
// empties both registers.
`default_nettype none
module stx_length_frame_receiver_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] data, [15:8] count_or_index
  output logic [2:0]       out_tuser   // [2:0] event_res
);

  import slfr_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_value;
  logic       advance;
  result_t    res;

  logic       out_valid_r, out_valid_nxt;
  event_t     out_ev_r;
  logic [7:0] out_data_r;
  logic [7:0] out_count_r;

  assign advance = byte_valid && (!out_valid_r || out_tready);

  slfr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_value (byte_value)
  );

  slfr_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .rx_byte (byte_value),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res.valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_ev_r    <= res.ev;
      out_data_r  <= res.data;
      out_count_r <= res.count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_data_r};
  assign out_tuser  = out_ev_r;

  // A byte that is not decoded must stay in the input register.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    byte_valid && !advance |=> byte_valid && $stable(byte_value))
    else $error("input byte lost while decode stalled");

  // Every decoded event shows up on the output in the following cycle.
  a_event_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.valid |=> out_tvalid && (out_tuser == $past(res.ev)))
    else $error("decoded event not presented on output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("registers not empty after reset");

endmodule
`default_nettype wire

// ===== tb/tb_stx_length_frame_receiver_core.sv =====
`timescale 1ns / 100ps

module tb_stx_length_frame_receiver_core;
  import slfr_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    event_t     ev;
    logic [7:0] data;
    logic [7:0] count;
  } link_event_t;

  // Tracks the frame parser state and holds the events the block still owes.
  class frame_scoreboard;
    phase_t       phase;
    logic [7:0]   body_len;
    logic [7:0]   body_pos;
    logic [7:0]   check_xor;
    logic [7:0]   cmd_byte;
    bit           etx_seen;
    link_event_t  pending_events[$];
    int           errors;

    function new();
      phase     = PH_IDLE;
      body_len  = '0;
      body_pos  = '0;
      check_xor = '0;
      cmd_byte  = '0;
      etx_seen  = 1'b0;
      errors    = 0;
    endfunction

    function void expect_event(event_t ev, logic [7:0] data, logic [7:0] count);
      link_event_t e;
      e.ev    = ev;
      e.data  = data;
      e.count = count;
      pending_events.push_back(e);
    endfunction

    function void note_byte(logic [7:0] b);
      int  p;
      int  len;
      bit  good;
      p   = body_pos;
      len = body_len;
      case (phase)
        PH_LEN: begin
          body_len  = b;
          check_xor = b;
          body_pos  = '0;
          etx_seen  = 1'b0;
          if (b == 8'd0) begin
            phase = PH_IDLE;
            expect_event(EV_NACK, '0, '0);
          end else begin
            phase = PH_BODY;
          end
        end
        PH_BODY: begin
          if (p + 1 >= len) begin
            good = (len >= MIN_BODY) && etx_seen && (b == check_xor);
            phase    = PH_IDLE;
            body_pos = '0;
            if (good) expect_event(EV_ACK, cmd_byte, 8'(len - MIN_BODY));
            else expect_event(EV_NACK, '0, '0);
          end else begin
            check_xor = check_xor ^ b;
            body_pos  = 8'(p + 1);
            if (p == 0) cmd_byte = b;
            if (p + 2 == len) etx_seen = (b == BYTE_ETX);
            // Command and three host status bytes come first; payload follows.
            if (p >= 4 && p + 3 <= len) expect_event(EV_PAYLOAD, b, 8'(p - 4));
          end
        end
        default: begin
          phase = PH_IDLE;
          if (b == BYTE_ENQ) expect_event(EV_POLL, '0, '0);
          else if (b == BYTE_STX) phase = PH_LEN;
          else expect_event(EV_DROP, b, '0);
        end
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_event(logic [2:0] ev, logic [7:0] data, logic [7:0] count);
      link_event_t e;
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected event ev=%0d data=%02h count=%0d", ev, data, count));
      end else begin
        e = pending_events.pop_front();
        if (ev !== e.ev || data !== e.data || count !== e.count)
          report($sformatf("event mismatch: expected ev=%0d data=%02h count=%0d, got ev=%0d data=%02h count=%0d",
                           e.ev, e.data, e.count, ev, data, count));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;

  frame_scoreboard sb = new();
  int          bytes_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int unsigned ready_cnt = 0;
  logic [7:0]  frame_bytes[$];

  stx_length_frame_receiver_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // The consumer cycles through full rate, random, periodic and long stalls.
  always @(posedge clk) begin
    ready_cnt <= ready_cnt + 1;
    case (ready_cnt[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 9) < 7);
      2'd2: out_tready <= (ready_cnt[1:0] != 2'd0);
      default: out_tready <= (ready_cnt[4:3] != 2'd0);
    endcase
    if (rst_n && out_tvalid && out_tready)
      sb.check_event(out_tuser, out_tdata[7:0], out_tdata[15:8]);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    if (burst_left == 0) begin
      // Every third stretch of about 150 bytes runs without sender gaps.
      if ((bytes_sent / 150) % 3 != 1) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
    burst_left--;
  endtask

  task automatic send_queued();
    while (frame_bytes.size() > 0) send_byte(frame_bytes.pop_front());
  endtask

  // A frame with random content; the flags spoil the end marker or the check byte.
  task automatic send_frame(int len, bit bad_etx, bit bad_chk);
    logic [7:0] x;
    logic [7:0] b;
    frame_bytes.push_back(BYTE_STX);
    frame_bytes.push_back(8'(len));
    x = 8'(len);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) begin
        b = bad_chk ? (x ^ 8'($urandom_range(1, 255))) : x;
      end else if (i == len - 2 && len >= MIN_BODY) begin
        if (bad_etx) begin
          b = 8'($urandom_range(0, 255));
          if (b == BYTE_ETX) b = 8'h04;
        end else begin
          b = BYTE_ETX;
        end
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      if (i < len - 1) x = x ^ b;
      frame_bytes.push_back(b);
    end
    send_queued();
  endtask

  initial begin
    int pick;
    int len;
    int flaw;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: poll, dropped bytes at both extremes, zero length,
    // a frame with no payload, a short body, control bytes inside a payload.
    send_byte(BYTE_ENQ);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(BYTE_STX);
    send_byte(8'h00);
    send_frame(6, 1'b0, 1'b0);
    send_frame(2, 1'b0, 1'b0);
    frame_bytes = '{BYTE_STX, 8'd8, 8'hFF, 8'h00, 8'h00, 8'h00,
                    BYTE_ENQ, BYTE_STX, BYTE_ETX, 8'hF3};
    send_queued();

    while (bytes_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 12) begin
        send_byte(BYTE_ENQ);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 4) len = $urandom_range(200, 255);
        else if (pick < 15) len = $urandom_range(0, 5);
        else len = $urandom_range(6, 24);
        flaw = $urandom_range(0, 9);
        send_frame(len, flaw == 0, flaw == 1);
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending_events.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/slfr_pkg.sv
rtl/slfr_in_reg.sv
rtl/slfr_frame_fsm.sv
rtl/stx_length_frame_receiver_core.sv
tb/tb_stx_length_frame_receiver_core.sv
